// ===== rtl/iqtr_pkg.sv =====
// Shared types and constants for the quarter-turn image rotator.
package iqtr_pkg;

   localparam int PIXEL_W   = 24;
   localparam int CHANNEL_W = 8;
   localparam int COORD_W   = 8;
   localparam int CSR_W     = 9;
   localparam int CSR_IDX_W = 3;
   localparam int SRC_W     = 10;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_LEFT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_TOP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_RIGHT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_BOTTOM   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TURNS        = 3'd6;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NOT_SQUARE = 2'd1,
      STATUS_RANGE      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_FETCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic store;
      logic capture;
      logic map;
      logic fetch;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/iqtr_ctrl.sv =====
// Controller state machine for the quarter-turn image rotator.
module iqtr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_command,
   output logic                  req_stall,
   input  iqtr_pkg::dp_status_type dp_status,
   output iqtr_pkg::ctl_cmd_type   ctl_cmd
);

   iqtr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iqtr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      ctl_cmd   = '0;
      unique case (state_ff)
         iqtr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_command == iqtr_pkg::CMD_READ) begin
                  ctl_cmd.capture = 1'b1;
                  state_in        = iqtr_pkg::ST_MAP;
               end else begin
                  ctl_cmd.store = 1'b1;
               end
            end
         end
         iqtr_pkg::ST_MAP: begin
            ctl_cmd.map = 1'b1;
            state_in    = iqtr_pkg::ST_FETCH;
         end
         iqtr_pkg::ST_FETCH: begin
            ctl_cmd.fetch = 1'b1;
            state_in      = iqtr_pkg::ST_FINISH;
         end
         iqtr_pkg::ST_FINISH: begin
            if (dp_status.out_free) begin
               ctl_cmd.finish = 1'b1;
               state_in       = iqtr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iqtr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/iqtr_datapath.sv =====
// Datapath: registers, coordinate map, pixel store and output register.
module iqtr_datapath #(
   parameter int MAX_SIDE = 256,
   parameter int CHANNELS = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  iqtr_pkg::ctl_cmd_type                ctl_cmd,
   output iqtr_pkg::dp_status_type              dp_status,
   input  logic [iqtr_pkg::COORD_W-1:0]         req_row,
   input  logic [iqtr_pkg::COORD_W-1:0]         req_col,
   input  logic [iqtr_pkg::PIXEL_W-1:0]         req_pixel_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [iqtr_pkg::PIXEL_W-1:0]         rsp_read_value,
   output logic [1:0]                           rsp_status,
   input  logic                                 csr_write_enable,
   input  logic [iqtr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [iqtr_pkg::CSR_W-1:0]           csr_write_data
);

   localparam int AW    = $clog2(MAX_SIDE);
   localparam int PW    = iqtr_pkg::CHANNEL_W * CHANNELS;
   localparam int DEPTH = 1 << (2 * AW);
   localparam int SW    = iqtr_pkg::SRC_W;
   localparam logic [31:0] SIDE_LIMIT = 32'(MAX_SIDE);
   localparam logic [SW-1:0] ONE = SW'(1);

   logic [iqtr_pkg::CSR_W-1:0] width_ff, height_ff;
   logic [iqtr_pkg::CSR_W-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic [1:0]                 turns_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd1;
         height_ff <= 9'd1;
         left_ff   <= 9'd0;
         top_ff    <= 9'd0;
         right_ff  <= 9'd1;
         bottom_ff <= 9'd1;
         turns_ff  <= 2'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            iqtr_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
            iqtr_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
            iqtr_pkg::CSR_SEL_LEFT:     left_ff   <= csr_write_data;
            iqtr_pkg::CSR_SEL_TOP:      top_ff    <= csr_write_data;
            iqtr_pkg::CSR_SEL_RIGHT:    right_ff  <= csr_write_data;
            iqtr_pkg::CSR_SEL_BOTTOM:   bottom_ff <= csr_write_data;
            iqtr_pkg::CSR_TURNS:        turns_ff  <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // captured read coordinate
   logic [iqtr_pkg::COORD_W-1:0] row_ff, col_ff;

   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
   end

   // coordinate map, all in modulo 2^SW arithmetic
   logic [SW-1:0] r10, c10, w10, h10, l10, t10, rt10, b10;
   logic [SW-1:0] side_x, side_y, rows10, cols10;
   logic          square, whole, side_pos, in_sel, out_hw;
   logic [SW-1:0] src_row_in, src_col_in;
   iqtr_pkg::status_type status_in;
   logic          fetch_en_in;

   assign r10  = SW'(row_ff);
   assign c10  = SW'(col_ff);
   assign w10  = SW'(width_ff);
   assign h10  = SW'(height_ff);
   assign l10  = SW'(left_ff);
   assign t10  = SW'(top_ff);
   assign rt10 = SW'(right_ff);
   assign b10  = SW'(bottom_ff);

   assign side_x   = rt10 - l10;
   assign side_y   = b10 - t10;
   assign square   = (side_x == side_y);
   assign side_pos = !side_x[SW-1] && (side_x != '0);
   assign whole    = (left_ff == '0) && (top_ff == '0) &&
                     (right_ff == width_ff) && (bottom_ff == height_ff);
   assign in_sel   = (r10 >= t10) && (r10 < b10) && (c10 >= l10) && (c10 < rt10);
   assign out_hw   = (r10 >= h10) || (c10 >= w10);
   assign rows10   = turns_ff[0] ? w10 : h10;
   assign cols10   = turns_ff[0] ? h10 : w10;

   always_comb begin
      src_row_in = r10;
      src_col_in = c10;
      status_in  = iqtr_pkg::STATUS_OK;
      if ((turns_ff == 2'd0) || square) begin
         if (out_hw) begin
            status_in = iqtr_pkg::STATUS_RANGE;
         end else if ((turns_ff != 2'd0) && side_pos && in_sel) begin
            case (turns_ff)
               2'd1: begin
                  src_row_in = t10 + rt10 - ONE - c10;
                  src_col_in = l10 + r10 - t10;
               end
               2'd2: begin
                  src_row_in = t10 + b10 - ONE - r10;
                  src_col_in = l10 + rt10 - ONE - c10;
               end
               default: begin
                  src_row_in = t10 + c10 - l10;
                  src_col_in = l10 + b10 - ONE - r10;
               end
            endcase
         end
      end else if (whole) begin
         if ((r10 >= rows10) || (c10 >= cols10)) begin
            status_in = iqtr_pkg::STATUS_RANGE;
         end else begin
            case (turns_ff)
               2'd1: begin
                  src_row_in = h10 - ONE - c10;
                  src_col_in = r10;
               end
               2'd2: begin
                  src_row_in = h10 - ONE - r10;
                  src_col_in = w10 - ONE - c10;
               end
               default: begin
                  src_row_in = c10;
                  src_col_in = w10 - ONE - r10;
               end
            endcase
         end
      end else if (out_hw) begin
         status_in = iqtr_pkg::STATUS_RANGE;
      end else begin
         status_in = iqtr_pkg::STATUS_NOT_SQUARE;
      end
   end

   assign fetch_en_in = (status_in != iqtr_pkg::STATUS_RANGE) &&
                        (32'(src_row_in) < SIDE_LIMIT) &&
                        (32'(src_col_in) < SIDE_LIMIT);

   logic [SW-1:0]        src_row_ff, src_col_ff;
   iqtr_pkg::status_type status_ff;
   logic                 fetch_en_ff;

   always_ff @(posedge clock) begin
      if (ctl_cmd.map) begin
         src_row_ff  <= src_row_in;
         src_col_ff  <= src_col_in;
         status_ff   <= status_in;
         fetch_en_ff <= fetch_en_in;
      end
   end

   // pixel store
   logic [PW-1:0]   pixel_store_ff [DEPTH];
   logic [PW-1:0]   mem_q_ff;
   logic [2*AW-1:0] wr_addr, rd_addr;
   logic            wr_in_range;

   assign wr_addr     = {AW'(req_row), AW'(req_col)};
   assign rd_addr     = {AW'(src_row_ff), AW'(src_col_ff)};
   assign wr_in_range = (32'(req_row) < SIDE_LIMIT) && (32'(req_col) < SIDE_LIMIT);

   always_ff @(posedge clock) begin
      if (ctl_cmd.store && wr_in_range) begin
         pixel_store_ff[wr_addr] <= PW'(req_pixel_value);
      end
      if (ctl_cmd.fetch) begin
         mem_q_ff <= pixel_store_ff[rd_addr];
      end
   end

   // output register
   logic                          rsp_valid_ff;
   logic [iqtr_pkg::PIXEL_W-1:0]  rsp_value_ff;
   iqtr_pkg::status_type          rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl_cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.finish) begin
         rsp_value_ff  <= fetch_en_ff ? iqtr_pkg::PIXEL_W'(mem_q_ff) : '0;
         rsp_status_ff <= status_ff;
      end
   end

   assign dp_status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_value_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// ===== rtl/image_quarter_turn_rotator.sv =====
// Top level of the quarter-turn image rotator.
// A write transfer (command 0) stores one pixel at its source row and column; writes at
// a coordinate at or beyond MAX_SIDE are dropped. A read transfer (command 1) maps the
// output coordinate to a source coordinate through the current turn count and selection,
// reads the pixel store and returns one result. The controller walks capture, map, store
// read and output load one after another, the output load waiting until the result
// register is free, before it takes the next transfer, so a new read is not accepted
// until the last one has loaded its result. A new transfer may be accepted while a
// result still waits on rsp_stall.
// The store is not cleared at reset: a read of a never-written pixel returns an
// arbitrary value. Write the csr registers only while no read is in flight.
module image_quarter_turn_rotator #(
   parameter int MAX_SIDE = 256,
   parameter int CHANNELS = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [iqtr_pkg::COORD_W-1:0]    req_row,
   input  logic [iqtr_pkg::COORD_W-1:0]    req_col,
   input  logic [iqtr_pkg::PIXEL_W-1:0]    req_pixel_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [iqtr_pkg::PIXEL_W-1:0]    rsp_read_value,
   output logic [1:0]                      rsp_status,
   input  logic                            csr_write_enable,
   input  logic [iqtr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [iqtr_pkg::CSR_W-1:0]      csr_write_data
);

   iqtr_pkg::ctl_cmd_type   ctl_cmd;
   iqtr_pkg::dp_status_type dp_status;

   iqtr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .dp_status   (dp_status),
      .ctl_cmd     (ctl_cmd)
   );

   iqtr_datapath #(
      .MAX_SIDE (MAX_SIDE),
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl_cmd          (ctl_cmd),
      .dp_status        (dp_status),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

// ===== tb/sv/image_quarter_turn_rotator_tb.sv =====
// Self-checking testbench for the quarter-turn image rotator.
module image_quarter_turn_rotator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 3000;
   localparam int LONG_HOLD     = 400;

   typedef struct packed {
      logic                         command;
      logic [iqtr_pkg::COORD_W-1:0] row;
      logic [iqtr_pkg::COORD_W-1:0] col;
      logic [iqtr_pkg::PIXEL_W-1:0] pixel;
   } pixel_cmd_type;

   typedef struct packed {
      logic [iqtr_pkg::PIXEL_W-1:0] value;
      iqtr_pkg::status_type         status;
   } pixel_answer_type;

   typedef struct packed {
      logic [iqtr_pkg::CSR_W-1:0] width;
      logic [iqtr_pkg::CSR_W-1:0] height;
      logic [iqtr_pkg::CSR_W-1:0] left;
      logic [iqtr_pkg::CSR_W-1:0] top;
      logic [iqtr_pkg::CSR_W-1:0] right;
      logic [iqtr_pkg::CSR_W-1:0] bottom;
      logic [1:0]                 turns;
   } frame_geom_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_command = iqtr_pkg::CMD_WRITE;
   logic [iqtr_pkg::COORD_W-1:0]   req_row = '0;
   logic [iqtr_pkg::COORD_W-1:0]   req_col = '0;
   logic [iqtr_pkg::PIXEL_W-1:0]   req_pixel_value = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [iqtr_pkg::PIXEL_W-1:0]   rsp_read_value;
   logic [1:0]                     rsp_status;
   logic                           csr_write_enable = 1'b0;
   logic [iqtr_pkg::CSR_IDX_W-1:0] csr_index = iqtr_pkg::CSR_IMAGE_WIDTH;
   logic [iqtr_pkg::CSR_W-1:0]     csr_write_data = '0;

   frame_geom_type geom = '{width: 9'd1, height: 9'd1, left: 9'd0, top: 9'd0,
                            right: 9'd1, bottom: 9'd1, turns: 2'd0};
   logic [iqtr_pkg::PIXEL_W-1:0] pix_mem [65536];
   bit                           loaded [65536];
   pixel_cmd_type                pixel_cmds [$];
   pixel_answer_type             expected_reads [$];
   pixel_cmd_type                next_cmd;
   pixel_answer_type             answer_due;
   int items_queued = 0;
   int mismatches = 0;
   int idle_odds = 0;
   int stall_odds = 0;
   int gap_left = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   bit long_hold_go = 1'b0;
   bit long_hold_done = 1'b0;

   image_quarter_turn_rotator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // output coordinate -> source store address; returns 0 when nothing is fetched
   function automatic bit map_to_source(input frame_geom_type g, input int ri, input int ci,
                                        output iqtr_pkg::status_type st, output int src);
      int w, h, lf, tp, rt, bt, sx, sy, n, i, j, sr, sc, orows, ocols;
      bit hit;
      w = int'(g.width);
      h = int'(g.height);
      lf = int'(g.left);
      tp = int'(g.top);
      rt = int'(g.right);
      bt = int'(g.bottom);
      sx = rt - lf;
      sy = bt - tp;
      st = iqtr_pkg::STATUS_OK;
      hit = 1'b0;
      sr = 0;
      sc = 0;
      if (g.turns == 2'd0 || sx == sy) begin
         if (ri >= h || ci >= w) begin
            st = iqtr_pkg::STATUS_RANGE;
         end else begin
            hit = 1'b1;
            sr = ri;
            sc = ci;
            if (g.turns != 2'd0 && sx > 0 && ri >= tp && ri < bt && ci >= lf && ci < rt) begin
               n = sx;
               i = ri - tp;
               j = ci - lf;
               case (g.turns)
                  2'd1: begin
                     sr = tp + n - 1 - j;
                     sc = lf + i;
                  end
                  2'd2: begin
                     sr = tp + n - 1 - i;
                     sc = lf + n - 1 - j;
                  end
                  default: begin
                     sr = tp + j;
                     sc = lf + n - 1 - i;
                  end
               endcase
            end
         end
      end else if (lf == 0 && tp == 0 && rt == w && bt == h) begin
         orows = g.turns[0] ? w : h;
         ocols = g.turns[0] ? h : w;
         if (ri >= orows || ci >= ocols) begin
            st = iqtr_pkg::STATUS_RANGE;
         end else begin
            hit = 1'b1;
            case (g.turns)
               2'd1: begin
                  sr = h - 1 - ci;
                  sc = ri;
               end
               2'd2: begin
                  sr = h - 1 - ri;
                  sc = w - 1 - ci;
               end
               default: begin
                  sr = ci;
                  sc = w - 1 - ri;
               end
            endcase
         end
      end else if (ri >= h || ci >= w) begin
         st = iqtr_pkg::STATUS_RANGE;
      end else begin
         st = iqtr_pkg::STATUS_NOT_SQUARE;
         hit = 1'b1;
         sr = ri;
         sc = ci;
      end
      if (sr > 255 || sc > 255) hit = 1'b0;
      src = sr * 256 + sc;
      return hit;
   endfunction

   function automatic pixel_answer_type predict_read(input logic [iqtr_pkg::COORD_W-1:0] r,
                                                     input logic [iqtr_pkg::COORD_W-1:0] c);
      pixel_answer_type     a;
      iqtr_pkg::status_type st;
      int                   src;
      bit                   hit;
      a.value = '0;
      hit = map_to_source(geom, int'(r), int'(c), st, src);
      if (hit) a.value = pix_mem[src];
      a.status = st;
      return a;
   endfunction

   function automatic void queue_write(input int r, input int c,
                                       input logic [iqtr_pkg::PIXEL_W-1:0] v);
      pixel_cmd_type cmd;
      cmd.command = iqtr_pkg::CMD_WRITE;
      cmd.row = 8'(r);
      cmd.col = 8'(c);
      cmd.pixel = v;
      loaded[r * 256 + c] = 1'b1;
      pixel_cmds.push_back(cmd);
      items_queued++;
   endfunction

   // loads the source pixel first when the read would land on an unwritten entry
   function automatic void queue_read(input int r, input int c);
      pixel_cmd_type        cmd;
      iqtr_pkg::status_type st;
      int                   src;
      bit                   hit;
      hit = map_to_source(geom, r, c, st, src);
      if (hit && !loaded[src])
         queue_write(src / 256, src % 256, 24'($urandom()));
      cmd.command = iqtr_pkg::CMD_READ;
      cmd.row = 8'(r);
      cmd.col = 8'(c);
      cmd.pixel = 24'($urandom());
      pixel_cmds.push_back(cmd);
      items_queued++;
   endfunction

   function automatic frame_geom_type random_geom();
      frame_geom_type g;
      int lim, w, h, side, d, lf, tp, rt, bt;
      lim = ($urandom_range(0, 5) == 0) ? 256 : 12;
      w = (lim == 256 && $urandom_range(0, 1) == 0) ? 256 : int'($urandom_range(1, lim));
      h = (lim == 256 && $urandom_range(0, 1) == 0) ? 256 : int'($urandom_range(1, lim));
      case ($urandom_range(0, 4))
         0: begin
            lf = 0;
            tp = 0;
            rt = w;
            bt = h;
         end
         1: begin
            side = $urandom_range(1, lim);
            lf = $urandom_range(0, lim - side);
            tp = $urandom_range(0, lim - side);
            rt = lf + side;
            bt = tp + side;
         end
         2: begin
            side = $urandom_range(1, (w < h) ? w : h);
            lf = $urandom_range(0, w - side);
            tp = $urandom_range(0, h - side);
            rt = lf + side;
            bt = tp + side;
         end
         3: begin
            d = $urandom_range(0, lim);
            lf = $urandom_range(d, lim);
            tp = $urandom_range(d, lim);
            rt = lf - d;
            bt = tp - d;
         end
         default: begin
            lf = $urandom_range(0, lim);
            tp = $urandom_range(0, lim);
            rt = $urandom_range(0, lim);
            bt = $urandom_range(0, lim);
         end
      endcase
      g.width = 9'(w);
      g.height = 9'(h);
      g.left = 9'(lf);
      g.top = 9'(tp);
      g.right = 9'(rt);
      g.bottom = 9'(bt);
      g.turns = 2'($urandom_range(0, 3));
      return g;
   endfunction

   function automatic void random_phase(input int n);
      int ext, w, h, k;
      w = int'(geom.width);
      h = int'(geom.height);
      ext = ((w > h) ? w : h) + 1;
      if (ext > 255) ext = 255;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 3) == 0)
               queue_read($urandom_range(0, 255), $urandom_range(0, 255));
            else
               queue_read($urandom_range(0, ext), $urandom_range(0, ext));
         end else if ($urandom_range(0, 3) == 0) begin
            queue_write($urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom()));
         end else begin
            queue_write($urandom_range(0, h - 1), $urandom_range(0, w - 1), 24'($urandom()));
         end
      end
   endfunction

   task automatic csr_put(input logic [iqtr_pkg::CSR_IDX_W-1:0] idx,
                          input logic [iqtr_pkg::CSR_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
   endtask

   task automatic set_geometry(input frame_geom_type g);
      csr_put(iqtr_pkg::CSR_IMAGE_WIDTH, g.width);
      csr_put(iqtr_pkg::CSR_IMAGE_HEIGHT, g.height);
      csr_put(iqtr_pkg::CSR_SEL_LEFT, g.left);
      csr_put(iqtr_pkg::CSR_SEL_TOP, g.top);
      csr_put(iqtr_pkg::CSR_SEL_RIGHT, g.right);
      csr_put(iqtr_pkg::CSR_SEL_BOTTOM, g.bottom);
      csr_put(iqtr_pkg::CSR_TURNS, {7'd0, g.turns});
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      geom = g;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pixel_cmds.size() != 0 || req_valid || expected_reads.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic directed_geometry(input int w, input int h, input int lf, input int tp,
                                    input int rt, input int bt, input int k);
      frame_geom_type g;
      g.width = 9'(w);
      g.height = 9'(h);
      g.left = 9'(lf);
      g.top = 9'(tp);
      g.right = 9'(rt);
      g.bottom = 9'(bt);
      g.turns = 2'(k);
      wait_idle();
      set_geometry(g);
   endtask

   // request side: records each accepted write and predicts each accepted read, then offers the next command
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_command == iqtr_pkg::CMD_WRITE)
               pix_mem[{req_row, req_col}] = req_pixel_value;
            else
               expected_reads.push_back(predict_read(req_row, req_col));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
               gap_left = $urandom_range(0, 18);
               req_valid <= 1'b0;
            end else if (pixel_cmds.size() != 0) begin
               next_cmd = pixel_cmds.pop_front();
               req_command <= next_cmd.command;
               req_row <= next_cmd.row;
               req_col <= next_cmd.col;
               req_pixel_value <= next_cmd.pixel;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side: checks each result transfer and drives the stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reads.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: value %06h status %0d",
                           rsp_read_value, rsp_status);
               mismatches++;
            end else begin
               answer_due = expected_reads.pop_front();
               if (rsp_read_value !== answer_due.value || rsp_status !== answer_due.status) begin
                  if (mismatches < 10)
                     $display("read mismatch: expected %06h/%0d, got %06h/%0d",
                              answer_due.value, answer_due.status,
                              rsp_read_value, rsp_status);
                  mismatches++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            hold_left = $urandom_range(0, 18);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry: 1x1 image, no turn
      queue_write(0, 0, 24'hFFFFFF);
      queue_write(255, 255, 24'h000000);
      queue_read(0, 0);
      queue_read(0, 1);
      queue_read(255, 255);
      // full 256x256 square, one turn: corners
      directed_geometry(256, 256, 0, 0, 256, 256, 1);
      queue_read(255, 0);
      queue_read(0, 255);
      directed_geometry(2, 2, 0, 0, 2, 2, 1);
      queue_read(0, 0);
      queue_read(0, 1);
      queue_read(1, 1);
      // whole non-square image turned: output dimensions swap
      directed_geometry(3, 1, 0, 0, 3, 1, 3);
      queue_read(2, 0);
      queue_read(0, 1);
      // partial non-square selection
      directed_geometry(3, 2, 0, 0, 2, 1, 2);
      queue_read(1, 2);
      queue_read(2, 0);
      // inverted square selection turns nothing
      directed_geometry(4, 4, 3, 3, 1, 1, 2);
      queue_read(0, 0);
      queue_read(3, 3);
      // zero turns with a square selection inside a non-square image
      directed_geometry(4, 2, 1, 0, 3, 2, 0);
      queue_read(1, 3);

      phase = 0;
      while (items_queued < 930) begin
         wait_idle();
         set_geometry(random_geom());
         if (items_queued > 820) begin
            idle_odds = 0;
            stall_odds = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: idle_odds = 0;
               1: idle_odds = 3;
               default: idle_odds = 10;
            endcase
            case ($urandom_range(0, 2))
               0: stall_odds = 0;
               1: stall_odds = 3;
               default: stall_odds = 10;
            endcase
         end
         if (phase == 0) begin
            idle_odds = 0;
            long_hold_go = 1'b1;
            random_phase(80);
         end else begin
            random_phase($urandom_range(20, 50));
         end
         phase++;
      end
      wait_idle();
      if (mismatches == 0 && expected_reads.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/iqtr_pkg.sv
rtl/iqtr_ctrl.sv
rtl/iqtr_datapath.sv
rtl/image_quarter_turn_rotator.sv
tb/sv/image_quarter_turn_rotator_tb.sv
